// ===== sv/smm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

  // Matrix geometry and storage.
  localparam int MAX_SIZE = 8;
  localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 4;
  localparam int CNT_W    = 7;

  // Arithmetic widths: Q8.8 elements, Q16.16 products, Q19.16 sums.
  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = 35;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_MATRIX_SIZE = 2'd0,
    REG_ROW_BEGIN   = 2'd1,
    REG_ROW_END     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] matrix_size;
    logic [SIZE_W-1:0] row_begin;
    logic [SIZE_W-1:0] row_end;
  } cfg_t;

  // Tags that travel with one multiply-accumulate step.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic issuing;
    logic rd_vld;
    logic draining;
    logic sum_done;
  } sts_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

// ===== sv/smm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one element of A and one of B per transaction.
interface smm_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [smm_pkg::DATA_W-1:0] a_value;
  logic signed [smm_pkg::DATA_W-1:0] b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

// Result channel: one element of C per transaction.
interface smm_out_if;
  logic                             valid;
  logic                             ready;
  logic [smm_pkg::IDX_W-1:0]        out_row;
  logic [smm_pkg::IDX_W-1:0]        out_col;
  logic signed [smm_pkg::SUM_W-1:0] product_value;
  logic                             is_last;

  modport source (output valid, output out_row, output out_col, output product_value,
                  output is_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input product_value,
                  input is_last, output ready);
endinterface

`default_nettype wire

// ===== sv/smm_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smm_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [smm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [smm_pkg::PDATA_W-1:0]  pwdata,
  output logic      [smm_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output smm_pkg::cfg_t                     cfg
);

  smm_pkg::cfg_t    cfg_r;
  smm_pkg::cfg_reg_t reg_idx;
  logic             wr_go;

  assign reg_idx = smm_pkg::cfg_reg_t'(paddr[smm_pkg::PADDR_W-1:2]);
  assign wr_go   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.matrix_size <= smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE);
      cfg_r.row_begin   <= '0;
      cfg_r.row_end     <= smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE);
    end else if (wr_go) begin
      case (reg_idx)
        smm_pkg::REG_MATRIX_SIZE: cfg_r.matrix_size <= pwdata[smm_pkg::SIZE_W-1:0];
        smm_pkg::REG_ROW_BEGIN:   cfg_r.row_begin   <= pwdata[smm_pkg::SIZE_W-1:0];
        smm_pkg::REG_ROW_END:     cfg_r.row_end     <= pwdata[smm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      smm_pkg::REG_MATRIX_SIZE: prdata[smm_pkg::SIZE_W-1:0] = cfg_r.matrix_size;
      smm_pkg::REG_ROW_BEGIN:   prdata[smm_pkg::SIZE_W-1:0] = cfg_r.row_begin;
      smm_pkg::REG_ROW_END:     prdata[smm_pkg::SIZE_W-1:0] = cfg_r.row_end;
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/smm_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smm_store (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [smm_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [smm_pkg::DATA_W-1:0]  wr_a,
  input  wire logic [smm_pkg::DATA_W-1:0]  wr_b,
  input  wire logic [smm_pkg::ADDR_W-1:0]  rd_addr_a,
  input  wire logic [smm_pkg::ADDR_W-1:0]  rd_addr_b,
  output logic      [smm_pkg::DATA_W-1:0]  rd_a_r,
  output logic      [smm_pkg::DATA_W-1:0]  rd_b_r
);

  logic [smm_pkg::DATA_W-1:0] a_mem [smm_pkg::DEPTH];
  logic [smm_pkg::DATA_W-1:0] b_mem [smm_pkg::DEPTH];

  // Both matrices share the load address; each has its own read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_mem[wr_addr] <= wr_a;
      b_mem[wr_addr] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= a_mem[rd_addr_a];
    rd_b_r <= b_mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== sv/smm_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smm_mac (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire smm_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [smm_pkg::DATA_W-1:0] a,
  input  wire logic signed [smm_pkg::DATA_W-1:0] b,
  output logic signed      [smm_pkg::SUM_W-1:0]  sum,
  output logic                                   sum_done
);

  logic signed [smm_pkg::PROD_W-1:0] prod_r;
  smm_pkg::mac_ctl_t                 p_ctl_r;
  logic signed [smm_pkg::SUM_W-1:0]  acc_r;
  logic signed [smm_pkg::SUM_W-1:0]  acc_nxt;
  logic                              done_r;

  // Multiply stage.
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl_r <= '0;
    end else begin
      p_ctl_r <= ctl;
    end
  end

  // Accumulate stage; the first term of a dot product restarts the sum.
  always_comb begin
    acc_nxt = (p_ctl_r.first ? '0 : acc_r)
            + {{(smm_pkg::SUM_W-smm_pkg::PROD_W){prod_r[smm_pkg::PROD_W-1]}}, prod_r};
  end

  always_ff @(posedge clk) begin
    if (p_ctl_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= p_ctl_r.vld && p_ctl_r.last;
    end
  end

  assign sum      = acc_r;
  assign sum_done = done_r;

endmodule

`default_nettype wire

// ===== sv/smm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smm_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire smm_pkg::cfg_t              cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  output logic                            wr_en,
  output logic [smm_pkg::ADDR_W-1:0]      wr_addr,
  output logic [smm_pkg::ADDR_W-1:0]      rd_addr_a,
  output logic [smm_pkg::ADDR_W-1:0]      rd_addr_b,
  output smm_pkg::mac_ctl_t               mac_ctl,
  input  wire logic                       sum_done,
  input  wire logic [smm_pkg::SUM_W-1:0]  sum,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic [smm_pkg::IDX_W-1:0]       out_row,
  output logic [smm_pkg::IDX_W-1:0]       out_col,
  output logic [smm_pkg::SUM_W-1:0]       out_value,
  output logic                            out_last,
  output smm_pkg::sts_t                   sts
);

  smm_pkg::state_t state_r, state_nxt;

  logic [smm_pkg::CNT_W-1:0]  load_cnt_r, load_cnt_nxt, cnt_inc, total;
  logic [smm_pkg::IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [smm_pkg::SIZE_W-1:0] n, rb, re;
  logic                       load_go, load_done, run_go;
  logic                       k_end, j_end, elem_last;
  logic                       issue, write_go, slot_free;
  smm_pkg::mac_ctl_t          rd_ctl_r;
  logic                       out_valid_r;
  logic [smm_pkg::IDX_W-1:0]  out_row_r, out_col_r;
  logic [smm_pkg::SUM_W-1:0]  out_value_r;
  logic                       out_last_r;

  // Effective size and row bounds, saturated into range.
  always_comb begin
    if (cfg.matrix_size == '0) begin
      n = smm_pkg::SIZE_W'(1);
    end else if (cfg.matrix_size > smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE)) begin
      n = smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE);
    end else begin
      n = cfg.matrix_size;
    end
    rb = (cfg.row_begin > n) ? n : cfg.row_begin;
    re = (cfg.row_end > n) ? n : cfg.row_end;
  end

  // Load counting; the transaction that reaches N*N completes the load.
  assign total     = smm_pkg::CNT_W'({4'd0, n} * {4'd0, n});
  assign cnt_inc   = load_cnt_r + smm_pkg::CNT_W'(1);
  assign load_go   = in_valid && in_ready;
  assign load_done = load_go && (cnt_inc >= total);
  assign run_go    = load_done && (re > rb);
  assign wr_en     = load_go;
  assign wr_addr   = load_cnt_r[smm_pkg::ADDR_W-1:0];

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (load_done) begin
      load_cnt_nxt = '0;
    end else if (load_go) begin
      load_cnt_nxt = cnt_inc;
    end
  end

  // Loop ends.
  assign k_end     = ({1'b0, k_r} + smm_pkg::SIZE_W'(1)) == n;
  assign j_end     = ({1'b0, j_r} + smm_pkg::SIZE_W'(1)) == n;
  assign elem_last = j_end && (({1'b0, i_r} + smm_pkg::SIZE_W'(1)) == re);
  assign slot_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smm_pkg::ST_LOAD:  if (run_go) state_nxt = smm_pkg::ST_ISSUE;
      smm_pkg::ST_ISSUE: if (k_end) state_nxt = smm_pkg::ST_DRAIN;
      smm_pkg::ST_DRAIN: if (sum_done) state_nxt = smm_pkg::ST_WRITE;
      smm_pkg::ST_WRITE: begin
        if (slot_free) begin
          state_nxt = elem_last ? smm_pkg::ST_LOAD : smm_pkg::ST_ISSUE;
        end
      end
      default: state_nxt = smm_pkg::ST_LOAD;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    write_go = 1'b0;
    case (state_r)
      smm_pkg::ST_LOAD:  in_ready = 1'b1;
      smm_pkg::ST_ISSUE: issue = 1'b1;
      smm_pkg::ST_WRITE: write_go = slot_free;
      default: ;
    endcase
  end

  // Row, column and term counters.
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (run_go) begin
      i_nxt = rb[smm_pkg::IDX_W-1:0];
      j_nxt = '0;
      k_nxt = '0;
    end else if (issue) begin
      k_nxt = k_end ? '0 : k_r + smm_pkg::IDX_W'(1);
    end else if (write_go && !elem_last) begin
      if (j_end) begin
        j_nxt = '0;
        i_nxt = i_r + smm_pkg::IDX_W'(1);
      end else begin
        j_nxt = j_r + smm_pkg::IDX_W'(1);
      end
    end
  end

  // Read addresses: A[i][k] and B[k][j].
  assign rd_addr_a = smm_pkg::ADDR_W'({3'd0, i_r} * {2'd0, n}) + smm_pkg::ADDR_W'(k_r);
  assign rd_addr_b = smm_pkg::ADDR_W'({3'd0, k_r} * {2'd0, n}) + smm_pkg::ADDR_W'(j_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smm_pkg::ST_LOAD;
      load_cnt_r  <= '0;
      rd_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      load_cnt_r     <= load_cnt_nxt;
      rd_ctl_r.vld   <= issue;
      rd_ctl_r.first <= issue && (k_r == '0);
      rd_ctl_r.last  <= issue && k_end;
      if (write_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Counters and the output register carry no reset.
  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    if (write_go) begin
      out_row_r   <= i_r;
      out_col_r   <= j_r;
      out_value_r <= sum;
      out_last_r  <= elem_last;
    end
  end

  assign mac_ctl   = rd_ctl_r;
  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  assign sts.issuing  = issue;
  assign sts.rd_vld   = rd_ctl_r.vld;
  assign sts.draining = (state_r == smm_pkg::ST_DRAIN);
  assign sts.sum_done = sum_done;

endmodule

`default_nettype wire

// ===== sv/square_matrix_multiply.sv =====
// In the load state a transaction is taken whenever one is valid. After the transaction
// that completes the N*N load, each result element is formed by N reads through the
// single shared multiply-accumulate unit, the read, multiply and accumulate registers
// and one write; elements are formed one at a time and loading is closed until a run
// ends. Reset (synchronous, rst_n low) clears the sequencer, load count and handshakes
// and sets matrix_size 8, row_begin 0, row_end 8; the stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module square_matrix_multiply (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  smm_in_if.sink                           in_ch,
  smm_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [smm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [smm_pkg::PDATA_W-1:0] pwdata,
  output logic      [smm_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  smm_pkg::cfg_t             cfg;
  smm_pkg::mac_ctl_t         mac_ctl;
  smm_pkg::sts_t             sts;
  logic                      wr_en;
  logic [smm_pkg::ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [smm_pkg::DATA_W-1:0] rd_a, rd_b;
  logic [smm_pkg::SUM_W-1:0]  sum, out_value;
  logic                      sum_done;

  smm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smm_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_a      (in_ch.a_value),
    .wr_b      (in_ch.b_value),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a_r    (rd_a),
    .rd_b_r    (rd_b)
  );

  smm_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .a        (rd_a),
    .b        (rd_b),
    .sum      (sum),
    .sum_done (sum_done)
  );

  smm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .mac_ctl   (mac_ctl),
    .sum_done  (sum_done),
    .sum       (sum),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_value (out_value),
    .out_last  (out_ch.is_last),
    .sts       (sts)
  );

  assign out_ch.product_value = out_value;

  // A finished dot product only appears while the sequencer waits for it.
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sts.sum_done |-> sts.draining)
    else $error("dot product finished outside the drain state");

  // Read data is tagged valid only in the cycle after a read was issued.
  a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    sts.rd_vld |-> $past(sts.issuing))
    else $error("read tag without an issued read");

  // While a result other than the last one of a run is pending, loading is closed.
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_last) |-> !in_ch.ready)
    else $error("input open while a run is still in progress");

endmodule

`default_nettype wire

// ===== tb/smm_checker.sv =====
`timescale 1ns / 1ps

module smm_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  smm_in_if                                in_mon,
  smm_out_if                               out_mon,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic                        pready,
  input  wire logic [smm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [smm_pkg::PDATA_W-1:0] pwdata,
  output int                               fail_count,
  output int                               pending,
  output int                               results_seen
);

  // One element of C as it should leave the block.
  typedef struct {
    logic [smm_pkg::IDX_W-1:0]        row;
    logic [smm_pkg::IDX_W-1:0]        col;
    logic signed [smm_pkg::SUM_W-1:0] value;
    logic                             last;
  } c_entry_t;

  // Shadow copy of the block's stores, load count and registers.
  logic signed [smm_pkg::DATA_W-1:0] a_mem [smm_pkg::DEPTH];
  logic signed [smm_pkg::DATA_W-1:0] b_mem [smm_pkg::DEPTH];
  logic [smm_pkg::CNT_W-1:0]         fill;
  smm_pkg::cfg_t                     cfg;
  c_entry_t                          c_due [$];
  int                                errs = 0;
  int                                seen = 0;

  assign fail_count   = errs;
  assign results_seen = seen;

  // A size of zero acts as one, anything above the maximum acts as the maximum.
  function automatic int eff_dim(input logic [smm_pkg::SIZE_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > smm_pkg::MAX_SIZE) return smm_pkg::MAX_SIZE;
    return int'(raw);
  endfunction

  // Queue every element of the selected rows of C = A * B, row-major.
  task automatic predict_rows();
    int       n;
    int       rb;
    int       re;
    longint   acc;
    c_entry_t e;
    n  = eff_dim(cfg.matrix_size);
    rb = (cfg.row_begin > n) ? n : int'(cfg.row_begin);
    re = (cfg.row_end > n) ? n : int'(cfg.row_end);
    for (int i = rb; i < re; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += longint'(a_mem[(i * n + k) % smm_pkg::DEPTH])
               * longint'(b_mem[(k * n + j) % smm_pkg::DEPTH]);
        end
        e.row   = smm_pkg::IDX_W'(i);
        e.col   = smm_pkg::IDX_W'(j);
        e.value = acc[smm_pkg::SUM_W-1:0];
        e.last  = (i == re - 1) && (j == n - 1);
        c_due.push_back(e);
      end
    end
  endtask

  // Store one pair of elements; the pair that fills the matrices starts a run.
  task automatic take_pair();
    int n;
    n = eff_dim(cfg.matrix_size);
    a_mem[fill[smm_pkg::ADDR_W-1:0]] = in_mon.a_value;
    b_mem[fill[smm_pkg::ADDR_W-1:0]] = in_mon.b_value;
    fill = fill + 1'b1;
    if (fill >= n * n) begin
      fill = '0;
      predict_rows();
    end
  endtask

  // Register writes land at once; unmapped addresses are dropped.
  task automatic apply_write();
    case (paddr[3:2])
      smm_pkg::REG_MATRIX_SIZE: cfg.matrix_size = pwdata[smm_pkg::SIZE_W-1:0];
      smm_pkg::REG_ROW_BEGIN:   cfg.row_begin   = pwdata[smm_pkg::SIZE_W-1:0];
      smm_pkg::REG_ROW_END:     cfg.row_end     = pwdata[smm_pkg::SIZE_W-1:0];
      default:                  ;
    endcase
  endtask

  // Compare one result transaction with the oldest element still due.
  task automatic check_result();
    c_entry_t want;
    seen++;
    if (c_due.size() == 0) begin
      $error("unexpected result: row %0d col %0d value %0d", out_mon.out_row,
             out_mon.out_col, out_mon.product_value);
      errs++;
    end else begin
      want = c_due.pop_front();
      if (out_mon.out_row !== want.row) begin
        $error("out_row: expected %0d, got %0d", want.row, out_mon.out_row);
        errs++;
      end
      if (out_mon.out_col !== want.col) begin
        $error("out_col: expected %0d, got %0d", want.col, out_mon.out_col);
        errs++;
      end
      if (out_mon.product_value !== want.value) begin
        $error("product_value: expected %0d, got %0d", want.value, out_mon.product_value);
        errs++;
      end
      if (out_mon.is_last !== want.last) begin
        $error("is_last: expected %0d, got %0d", want.last, out_mon.is_last);
        errs++;
      end
    end
  endtask

  // Sample every handshake at the clock edge at which it completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      fill            = '0;
      cfg.matrix_size = smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE);
      cfg.row_begin   = '0;
      cfg.row_end     = smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE);
      c_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (psel && penable && pwrite && pready) begin
        apply_write();
      end
      if (in_mon.valid && in_mon.ready) begin
        take_pair();
      end
    end
    pending <= c_due.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] REG_UNMAPPED  = 2'd3;
  localparam int         RANDOM_ITEMS  = 200;
  localparam int         SETTLE_CYCLES = 4 * (smm_pkg::MAX_SIZE + 4);

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [smm_pkg::PADDR_W-1:0] paddr;
  logic [smm_pkg::PDATA_W-1:0] pwdata;
  logic [smm_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  logic                        result_ready = 1'b0;
  bit                          quiet = 1'b0;
  bit                          feeding = 1'b0;
  int                          fail_count;
  int                          pending;
  int                          results_seen;
  int                          items_fed = 0;
  int                          loaded = 0;
  int                          shapes = 0;
  int                          random_items = 0;
  logic [smm_pkg::SIZE_W-1:0]  size_reg = smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE);

  smm_in_if  in_ch ();
  smm_out_if out_ch ();

  assign out_ch.ready = result_ready;

  square_matrix_multiply dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  smm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side stalls at random about 9 percent of the time, except in the quiet stretch.
  always @(posedge clk) begin
    result_ready <= quiet || ($urandom_range(99) >= 9);
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int dim_of(input logic [smm_pkg::SIZE_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > smm_pkg::MAX_SIZE) return smm_pkg::MAX_SIZE;
    return int'(raw);
  endfunction

  // Q8.8 element: extremes now and then, otherwise any bit pattern.
  function automatic logic [smm_pkg::DATA_W-1:0] pick_element();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return smm_pkg::DATA_W'($urandom());
    endcase
  endfunction

  // Mostly small matrices, a few at full size or beyond, some zero.
  function automatic logic [smm_pkg::SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 20) return smm_pkg::SIZE_W'($urandom_range(smm_pkg::MAX_SIZE, 15));
    if (r < 60) return smm_pkg::SIZE_W'($urandom_range(1, 3));
    return smm_pkg::SIZE_W'($urandom_range(1, smm_pkg::MAX_SIZE - 1));
  endfunction

  function automatic logic [smm_pkg::SIZE_W-1:0] pick_bound(input int n, input bit upper);
    int r;
    r = $urandom_range(99);
    if (r < 15) return smm_pkg::SIZE_W'($urandom_range(0, 15));
    if (r < 60) return upper ? smm_pkg::SIZE_W'(n) : '0;
    return smm_pkg::SIZE_W'($urandom_range(0, n));
  endfunction

  // One register write: setup then access. With more set, psel stays high
  // and the next write's setup follows directly.
  task automatic write_reg(input logic [1:0] idx, input logic [smm_pkg::SIZE_W-1:0] value,
                           input bit more);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= smm_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= (smm_pkg::PDATA_W'($urandom()) << smm_pkg::SIZE_W)
             | smm_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == smm_pkg::REG_MATRIX_SIZE) size_reg = value;
    if (!more) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  task automatic set_shape(input logic [smm_pkg::SIZE_W-1:0] n,
                           input logic [smm_pkg::SIZE_W-1:0] rb,
                           input logic [smm_pkg::SIZE_W-1:0] re);
    write_reg(smm_pkg::REG_MATRIX_SIZE, n, 1'b1);
    write_reg(smm_pkg::REG_ROW_BEGIN, rb, 1'b1);
    write_reg(smm_pkg::REG_ROW_END, re, 1'b0);
    shapes++;
  endtask

  // Present one element pair and hold it until the block takes it.
  task automatic feed_pair(input logic [smm_pkg::DATA_W-1:0] a,
                           input logic [smm_pkg::DATA_W-1:0] b);
    if (!feeding) in_ch.valid <= 1'b1;
    feeding = 1'b1;
    in_ch.a_value <= a;
    in_ch.b_value <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_fed++;
    loaded++;
    if (loaded >= dim_of(size_reg) * dim_of(size_reg)) loaded = 0;
    if (!quiet && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      feeding = 1'b0;
      @(posedge clk);
    end
  endtask

  // Feed random pairs until the current load completes.
  task automatic load_run();
    do feed_pair(pick_element(), pick_element()); while (loaded != 0);
  endtask

  // Drain every due result, then give the block time to go idle.
  task automatic settle();
    if (feeding) in_ch.valid <= 1'b0;
    feeding = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                         n;
    int                         base;
    logic [smm_pkg::SIZE_W-1:0] raw;
    in_ch.valid   <= 1'b0;
    in_ch.a_value <= '0;
    in_ch.b_value <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_n         <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // One by one: the row range saturates at N, extreme products.
    set_shape(4'd1, 4'd0, 4'd8);
    feed_pair(16'h7FFF, 16'h7FFF);
    feed_pair(16'h8000, 16'h8000);
    feed_pair(16'h8000, 16'h7FFF);
    feed_pair(16'h0000, 16'hFFFF);
    settle();

    // A write to an unmapped address must change nothing.
    write_reg(REG_UNMAPPED, 4'hF, 1'b0);
    feed_pair(16'h0100, 16'hFF00);
    settle();

    // Size zero behaves as size one.
    set_shape(4'd0, 4'd0, 4'd15);
    feed_pair(16'hFFFF, 16'h0001);
    settle();

    // Partial row range, then an empty one.
    set_shape(4'd2, 4'd1, 4'd2);
    load_run();
    settle();
    set_shape(4'd2, 4'd8, 4'd0);
    load_run();
    settle();

    // Shrink the size in the middle of a load; the next pair completes it.
    set_shape(4'd3, 4'd0, 4'd3);
    repeat (4) feed_pair(pick_element(), pick_element());
    settle();
    write_reg(smm_pkg::REG_MATRIX_SIZE, 4'd2, 1'b0);
    load_run();
    settle();

    // Random runs, often back to back, sometimes reshaped or cut mid-load.
    while (random_items < RANDOM_ITEMS) begin
      base  = items_fed;
      quiet = (random_items >= 90) && (random_items < 150);
      if (random_items == 0 || $urandom_range(2) == 0) begin
        settle();
        raw = pick_size();
        n   = dim_of(raw);
        set_shape(raw, pick_bound(n, 1'b0), pick_bound(n, 1'b1));
      end
      n = dim_of(size_reg);
      if ($urandom_range(9) == 0 && n > 1) begin
        repeat ($urandom_range(1, n * n - 1)) feed_pair(pick_element(), pick_element());
        settle();
        write_reg(smm_pkg::REG_MATRIX_SIZE, pick_size(), 1'b0);
      end
      load_run();
      random_items += items_fed - base;
    end
    quiet = 1'b0;
    settle();

    $display("Loaded %0d element pairs under %0d register settings.", items_fed, shapes);
    $display("Compared %0d result transactions with the predicted products.", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
